// ===== sv/adcs_pkg.sv =====
`timescale 1ns / 1ps

package adcs_pkg;

  // scan geometry
  localparam int NUM_SLOTS_DEF = 10;
  localparam int CODE_W        = 5;
  localparam int MAP_SLOTS     = 10;
  localparam int MAP_W         = CODE_W * MAP_SLOTS;

  // field widths
  localparam int REQ_W    = 2;
  localparam int SAMPLE_W = 12;
  localparam int RCH_W    = 8;
  localparam int TIMER_W  = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MAP_W;

  // register reset values
  localparam logic [MAP_W-1:0]   MAP_RST   = '0;
  localparam logic [TIMER_W-1:0] SHORT_RST = 24'd10;
  localparam logic [TIMER_W-1:0] LONG_RST  = 24'd500;
  localparam logic [TIMER_W-1:0] FIRST_RST = 24'd5000;
  localparam logic               BATT_RST  = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_DONE = 2'd1,
    REQ_READ = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_MAP    = 3'd0,
    CFG_SHORT_INTERVAL = 3'd1,
    CFG_LONG_INTERVAL  = 3'd2,
    CFG_FIRST_DELAY    = 3'd3,
    CFG_BATT_ENABLE    = 3'd4
  } cfg_reg_t;

endpackage

// ===== sv/adcs_in_if.sv =====
`timescale 1ns / 1ps

interface adcs_in_if import adcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SAMPLE_W-1:0] sample_value;
  logic [RCH_W-1:0]    read_channel;

  modport source (output valid, req_type, sample_value, read_channel, input ready);
  modport sink   (input valid, req_type, sample_value, read_channel, output ready);
endinterface

// ===== sv/adcs_out_if.sv =====
`timescale 1ns / 1ps

interface adcs_out_if import adcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                start_conversion;
  logic [CODE_W-1:0]   conversion_channel;
  logic [SAMPLE_W-1:0] read_data;
  logic                battery_check_drive;

  modport source (output valid, start_conversion, conversion_channel, read_data,
                  battery_check_drive, input ready);
  modport sink   (input valid, start_conversion, conversion_channel, read_data,
                  battery_check_drive, output ready);
endinterface

// ===== sv/adcs_cfg_if.sv =====
`timescale 1ns / 1ps

interface adcs_cfg_if import adcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/adcs_ram.sv =====
`timescale 1ns / 1ps

module adcs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 10,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/adc_channel_scan_scheduler.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// in_ch     in   valid/ready           req_type, sample_value, read_channel
// out_ch    out  valid/ready           start_conversion, conversion_channel,
//                                      read_data, battery_check_drive
// cfg_ch    in   valid/ready (ready=1) index, data
//
// One word accepted per cycle while in_ch is ready; each gives one result word,
// registered first in the read stage (with the sample store read), then in the output register.
// Scheduler state updates at the accept edge, so no forwarding is needed.
// rst_n is synchronous; store entries are cleared by per-entry valid flags.
// in_ch stalls only when both the read stage and the output register are full
// and out_ch is not ready.

module adc_channel_scan_scheduler import adcs_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  adcs_in_if.sink  in_ch,
  adcs_out_if.source out_ch,
  adcs_cfg_if.sink cfg_ch
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int RCH_N  = 1 << RCH_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_ZERO = '0;
  localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);

  // configuration registers
  logic [MAP_W-1:0]   map_r;
  logic [TIMER_W-1:0] short_r;
  logic [TIMER_W-1:0] long_r;
  logic               batt_en_r;

  // scheduler state
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic               batt_r, batt_nxt;
  logic [NUM_SLOTS-1:0] written_r;

  // read stage
  logic              s1_valid_r;
  logic              s1_start_r, s1_start_nxt;
  logic [CODE_W-1:0] s1_chan_r, s1_chan_nxt;
  logic              s1_rd_r, s1_rd_nxt;
  logic              s1_hit_r;
  logic              s1_batt_r;

  // output register
  logic                out_valid_r;
  logic                out_start_r;
  logic [CODE_W-1:0]   out_chan_r;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                out_batt_r;

  logic                in_acc;
  logic                s1_move;
  logic                ram_we;
  logic                ram_re;
  logic [SLOT_W-1:0]   rd_slot;
  logic [SAMPLE_W-1:0] ram_q;

  logic [SLOT_W-1:0] mod_tbl [RCH_N];
  logic [CODE_W-1:0] slot_code [NUM_SLOTS];

  // read channel to slot, constant table
  for (genvar i = 0; i < RCH_N; i++) begin : g_mod
    assign mod_tbl[i] = SLOT_W'(i % NUM_SLOTS);
  end

  // channel code per slot, slots past the map read code 0
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_code
    if (i < MAP_SLOTS) begin : g_in
      assign slot_code[i] = map_r[i*CODE_W +: CODE_W];
    end else begin : g_out
      assign slot_code[i] = '0;
    end
  end

  // handshakes
  assign s1_move      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign rd_slot      = mod_tbl[in_ch.read_channel];

  // configuration writes; first_delay only matters at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r     <= MAP_RST;
      short_r   <= SHORT_RST;
      long_r    <= LONG_RST;
      batt_en_r <= BATT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_CHANNEL_MAP:    map_r     <= cfg_ch.data[MAP_W-1:0];
        CFG_SHORT_INTERVAL: short_r   <= cfg_ch.data[TIMER_W-1:0];
        CFG_LONG_INTERVAL:  long_r    <= cfg_ch.data[TIMER_W-1:0];
        CFG_FIRST_DELAY:    ;
        CFG_BATT_ENABLE:    batt_en_r <= cfg_ch.data[0];
        default:            ;
      endcase
    end
  end

  // timer, slot and battery drive update per accepted word
  always_comb begin
    slot_nxt     = slot_r;
    timer_nxt    = timer_r;
    batt_nxt     = batt_r;
    s1_start_nxt = 1'b0;
    s1_chan_nxt  = '0;
    s1_rd_nxt    = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    if (in_acc) begin
      case (req_type_t'(in_ch.req_type))
        REQ_TICK: begin
          if (timer_r != '0) begin
            timer_nxt = timer_r - TIMER_W'(1);
            if (timer_r == TIMER_W'(1)) begin
              s1_start_nxt = 1'b1;
              s1_chan_nxt  = slot_code[slot_r];
            end
          end
        end
        REQ_DONE: begin
          ram_we = 1'b1;
          if (slot_r == SLOT_ONE) begin
            batt_nxt = 1'b0;
          end
          if (slot_r == LAST_SLOT) begin
            slot_nxt  = '0;
            timer_nxt = long_r;
          end else begin
            slot_nxt  = slot_r + SLOT_W'(1);
            timer_nxt = short_r;
            if (slot_r == SLOT_ZERO && batt_en_r) begin
              batt_nxt = 1'b1;
            end
          end
        end
        REQ_READ: begin
          ram_re    = 1'b1;
          s1_rd_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      timer_r   <= FIRST_RST;
      batt_r    <= 1'b0;
      written_r <= '0;
    end else begin
      slot_r  <= slot_nxt;
      timer_r <= timer_nxt;
      batt_r  <= batt_nxt;
      if (ram_we) begin
        written_r[slot_r] <= 1'b1;
      end
    end
  end

  // sample store
  adcs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (NUM_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (in_ch.sample_value),
    .re    (ram_re),
    .raddr (rd_slot),
    .rdata (ram_q)
  );

  // read stage, waits for store data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_start_r <= s1_start_nxt;
      s1_chan_r  <= s1_chan_nxt;
      s1_rd_r    <= s1_rd_nxt;
      s1_hit_r   <= written_r[rd_slot];
      s1_batt_r  <= batt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_start_r <= s1_start_r;
      out_chan_r  <= s1_chan_r;
      out_data_r  <= (s1_rd_r && s1_hit_r) ? ram_q : '0;
      out_batt_r  <= s1_batt_r;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.start_conversion    = out_start_r;
  assign out_ch.conversion_channel  = out_chan_r;
  assign out_ch.read_data           = out_data_r;
  assign out_ch.battery_check_drive = out_batt_r;

endmodule

// ===== sv/adcs_checker.sv =====
`timescale 1ns / 1ps

module adcs_checker import adcs_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_start,
  input logic [CODE_W-1:0]   out_chan,
  input logic [SAMPLE_W-1:0] out_data
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a result word waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a starting tick never carries read data
  a_start_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start |-> out_data == '0)
    else $error("read data on a conversion start");

  // channel code only with a start
  a_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_start |-> out_chan == '0)
    else $error("channel code without a start");

  // a fresh result follows an accepted word, checked with $past
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result without an accepted word");

endmodule

bind adc_channel_scan_scheduler adcs_checker u_adcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_start (out_ch.start_conversion),
  .out_chan  (out_ch.conversion_channel),
  .out_data  (out_ch.read_data)
);
